FILE: rtl/mm_pkg.sv
// mm_pkg: shared constants, codes, types and helpers of the matrix multiply block
// no dependencies
package mm_pkg;

  localparam int MAX_DIM     = 8;
  localparam int VALUE_BITS  = 16;

  localparam int IN_BITS     = 16;
  localparam int DIM_FIELD   = 4;
  localparam int POS_BITS    = 3;
  localparam int ACC_BITS    = 35;
  localparam int PROD_BITS   = 2 * VALUE_BITS;
  localparam int CELLS       = MAX_DIM * MAX_DIM;
  localparam int ADDR_BITS   = $clog2(CELLS);
  localparam int IDX_BITS    = $clog2(MAX_DIM);
  localparam int CNT_BITS    = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_COMPUTE    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_ROWS_A     = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_COLS_B     = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic                 wr_left;
    logic                 wr_right;
    logic [ADDR_BITS-1:0] wr_addr;
    logic                 clear;
    logic                 issue;
    logic [ADDR_BITS-1:0] left_addr;
    logic [ADDR_BITS-1:0] right_addr;
    logic                 load_out;
    logic [POS_BITS-1:0]  row;
    logic [POS_BITS-1:0]  col;
    logic                 last;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } dp_stat_t;

  function automatic logic [CNT_BITS-1:0] clamp_dim(input logic [DIM_FIELD-1:0] d);
    logic [CNT_BITS-1:0] r;
    if (d > DIM_FIELD'(MAX_DIM)) r = CNT_BITS'(MAX_DIM);
    else r = CNT_BITS'(d);
    return r;
  endfunction

  // stored element: low bits of the loaded word, zero above it
  function automatic logic [VALUE_BITS-1:0] fit_value(input logic [IN_BITS-1:0] v);
    logic [VALUE_BITS-1:0] f;
    f = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (i < IN_BITS) f[i] = v[i];
    end
    return f;
  endfunction

endpackage

FILE: rtl/mm_in_if.sv
// mm_in_if: input item channel (load and compute transactions)
// depends on mm_pkg
interface mm_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [mm_pkg::POS_BITS-1:0]   row_index;
  logic [mm_pkg::POS_BITS-1:0]   col_index;
  logic signed [mm_pkg::IN_BITS-1:0] element_value;

  modport source (output valid, op, row_index, col_index, element_value, input ready);
  modport sink (input valid, op, row_index, col_index, element_value, output ready);
endinterface

FILE: rtl/mm_out_if.sv
// mm_out_if: result element channel
// depends on mm_pkg
interface mm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mm_pkg::ACC_BITS-1:0] product_value;
  logic [mm_pkg::POS_BITS-1:0]        result_row;
  logic [mm_pkg::POS_BITS-1:0]        result_col;
  logic                               last;

  modport source (output valid, product_value, result_row, result_col, last, input ready);
  modport sink (input valid, product_value, result_row, result_col, last, output ready);
endinterface

FILE: rtl/mm_cfg_if.sv
// mm_cfg_if: configuration register write channel
// depends on mm_pkg
interface mm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     index;
  logic [mm_pkg::DIM_FIELD-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/matrix_multiply.sv
// matrix_multiply: top level, C = A x B over signed Q8.8 elements, Q19.16 results
// depends on mm_pkg, mm_in_if, mm_out_if, mm_cfg_if, mm_ctrl, mm_datapath
//
// Load transactions write one element of A (op 0) or B (op 1); a load with a row or column
// at or above MAX_DIM is dropped. A compute transaction (op 2) streams rows_a x cols_b
// results in row-major order with last on the final one, and occupies the block until the
// last of them is in the result register: one multiply-accumulate unit does one product per
// cycle within an element, and each element passes the registered store read, the product
// register and the transfer into the result register, held off until that register is free.
// With inner_size zero every element is zero. Dimension registers above MAX_DIM act as
// MAX_DIM; zero rows or columns give no results. The result register lets the next element
// be computed, or the next transaction accepted, while a result waits.
module matrix_multiply (
  input  logic       clk,
  input  logic       rst,
  mm_in_if.sink      item,
  mm_out_if.source   result,
  mm_cfg_if.sink     cfg
);

  mm_pkg::dp_cmd_t  cmd;
  mm_pkg::dp_stat_t stat;

  mm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .op         (item.op),
    .row_index  (item.row_index),
    .col_index  (item.col_index),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat)
  );

  mm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .element_value (item.element_value),
    .result        (result)
  );

endmodule

FILE: rtl/mm_datapath.sv
// mm_datapath: element stores, multiply-accumulate pipeline and result register
// depends on mm_pkg, mm_out_if
module mm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  mm_pkg::dp_cmd_t                     cmd,
  output mm_pkg::dp_stat_t                    stat,
  input  logic signed [mm_pkg::IN_BITS-1:0]   element_value,
  mm_out_if.source                            result
);

  logic [mm_pkg::VALUE_BITS-1:0] left_mem  [mm_pkg::CELLS];
  logic [mm_pkg::VALUE_BITS-1:0] right_mem [mm_pkg::CELLS];
  logic [mm_pkg::VALUE_BITS-1:0] left_rd;
  logic [mm_pkg::VALUE_BITS-1:0] right_rd;
  logic signed [mm_pkg::PROD_BITS-1:0] prod;
  logic signed [mm_pkg::ACC_BITS-1:0]  acc;
  logic                                mac_v1;
  logic                                mac_v2;
  logic                                out_valid;
  logic signed [mm_pkg::ACC_BITS-1:0]  out_value;
  logic [mm_pkg::POS_BITS-1:0]         out_row;
  logic [mm_pkg::POS_BITS-1:0]         out_col;
  logic                                out_last;

  always_ff @(posedge clk) begin
    if (cmd.wr_left) left_mem[cmd.wr_addr] <= mm_pkg::fit_value(element_value);
    if (cmd.wr_right) right_mem[cmd.wr_addr] <= mm_pkg::fit_value(element_value);
    left_rd  <= left_mem[cmd.left_addr];
    right_rd <= right_mem[cmd.right_addr];
  end

  always_ff @(posedge clk) begin
    prod <= $signed(left_rd) * $signed(right_rd);
    if (cmd.clear) acc <= '0;
    else if (mac_v2) acc <= acc + mm_pkg::ACC_BITS'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_v1 <= 1'b0;
      mac_v2 <= 1'b0;
    end else begin
      mac_v1 <= cmd.issue;
      mac_v2 <= mac_v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value <= acc;
      out_row   <= cmd.row;
      out_col   <= cmd.col;
      out_last  <= cmd.last;
    end
  end

  assign stat.busy     = mac_v1 | mac_v2;
  assign stat.out_free = !out_valid || result.ready;

  assign result.valid         = out_valid;
  assign result.product_value = out_value;
  assign result.result_row    = out_row;
  assign result.result_col    = out_col;
  assign result.last          = out_last;

endmodule

FILE: rtl/mm_ctrl.sv
// mm_ctrl: configuration registers and sequencer over rows, columns and inner index
// depends on mm_pkg, mm_cfg_if
module mm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         op,
  input  logic [mm_pkg::POS_BITS-1:0] row_index,
  input  logic [mm_pkg::POS_BITS-1:0] col_index,
  mm_cfg_if.sink             cfg,
  output mm_pkg::dp_cmd_t    cmd,
  input  mm_pkg::dp_stat_t   stat
);

  mm_pkg::state_t                state, state_next;
  logic [mm_pkg::DIM_FIELD-1:0]  rows_a, inner_size, cols_b;
  logic [mm_pkg::CNT_BITS-1:0]   nr, nk, nc, nr_next, nk_next, nc_next;
  logic [mm_pkg::IDX_BITS-1:0]   r, c, k, r_next, c_next, k_next;
  logic                          in_range;
  logic                          last_k, last_c, last_elem;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= mm_pkg::DIM_FIELD'(8);
      inner_size <= mm_pkg::DIM_FIELD'(8);
      cols_b     <= mm_pkg::DIM_FIELD'(8);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mm_pkg::CFG_ROWS_A:     rows_a     <= cfg.data;
        mm_pkg::CFG_INNER_SIZE: inner_size <= cfg.data;
        mm_pkg::CFG_COLS_B:     cols_b     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mm_pkg::S_IDLE;
      nr    <= '0;
      nk    <= '0;
      nc    <= '0;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      nr    <= nr_next;
      nk    <= nk_next;
      nc    <= nc_next;
      r     <= r_next;
      c     <= c_next;
      k     <= k_next;
    end
  end

  assign in_range = ({1'b0, row_index} < 4'(mm_pkg::MAX_DIM)) &&
                    ({1'b0, col_index} < 4'(mm_pkg::MAX_DIM));
  assign last_k    = (mm_pkg::CNT_BITS'(k) + mm_pkg::CNT_BITS'(1)) == nk;
  assign last_c    = (mm_pkg::CNT_BITS'(c) + mm_pkg::CNT_BITS'(1)) == nc;
  assign last_elem = last_c && ((mm_pkg::CNT_BITS'(r) + mm_pkg::CNT_BITS'(1)) == nr);

  always_comb begin
    state_next = state;
    nr_next    = nr;
    nk_next    = nk;
    nc_next    = nc;
    r_next     = r;
    c_next     = c;
    k_next     = k;
    item_ready = 1'b0;

    cmd            = '0;
    cmd.wr_addr    = mm_pkg::ADDR_BITS'(mm_pkg::ADDR_BITS'(row_index) *
                     mm_pkg::ADDR_BITS'(mm_pkg::MAX_DIM) + mm_pkg::ADDR_BITS'(col_index));
    cmd.left_addr  = mm_pkg::ADDR_BITS'(mm_pkg::ADDR_BITS'(r) *
                     mm_pkg::ADDR_BITS'(mm_pkg::MAX_DIM) + mm_pkg::ADDR_BITS'(k));
    cmd.right_addr = mm_pkg::ADDR_BITS'(mm_pkg::ADDR_BITS'(k) *
                     mm_pkg::ADDR_BITS'(mm_pkg::MAX_DIM) + mm_pkg::ADDR_BITS'(c));
    cmd.row        = mm_pkg::POS_BITS'(r);
    cmd.col        = mm_pkg::POS_BITS'(c);
    cmd.last       = last_elem;

    unique case (state)
      mm_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          unique case (op)
            mm_pkg::OP_LOAD_LEFT:  cmd.wr_left  = in_range;
            mm_pkg::OP_LOAD_RIGHT: cmd.wr_right = in_range;
            mm_pkg::OP_COMPUTE: begin
              cmd.clear = 1'b1;
              nr_next   = mm_pkg::clamp_dim(rows_a);
              nk_next   = mm_pkg::clamp_dim(inner_size);
              nc_next   = mm_pkg::clamp_dim(cols_b);
              r_next    = '0;
              c_next    = '0;
              k_next    = '0;
              if (nr_next == '0 || nc_next == '0) state_next = mm_pkg::S_IDLE;
              else if (nk_next == '0) state_next = mm_pkg::S_WAIT;
              else state_next = mm_pkg::S_MAC;
            end
            default: ;
          endcase
        end
      end
      mm_pkg::S_MAC: begin
        cmd.issue = 1'b1;
        if (last_k) begin
          k_next     = '0;
          state_next = mm_pkg::S_WAIT;
        end else begin
          k_next = k + mm_pkg::IDX_BITS'(1);
        end
      end
      mm_pkg::S_WAIT: begin
        if (!stat.busy && stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          if (last_elem) begin
            state_next = mm_pkg::S_IDLE;
          end else begin
            if (last_c) begin
              c_next = '0;
              r_next = r + mm_pkg::IDX_BITS'(1);
            end else begin
              c_next = c + mm_pkg::IDX_BITS'(1);
            end
            state_next = (nk == '0) ? mm_pkg::S_WAIT : mm_pkg::S_MAC;
          end
        end
      end
      default: state_next = mm_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: verif/matrix_multiply_test.sv
// matrix_multiply_test: self-checking bench for matrix_multiply, a directed table then random
// phases of dimension writes, element loads and products, checked against a local model
// depends on mm_pkg, mm_in_if, mm_out_if, mm_cfg_if and matrix_multiply
module matrix_multiply_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 230;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [1:0]                   op;
    logic [POS_BITS-1:0]          row;
    logic [POS_BITS-1:0]          col;
    logic signed [IN_BITS-1:0]    value;
    cfg_index_t                   reg_index;
    logic [DIM_FIELD-1:0]         reg_data;
    logic                         checked;
    logic signed [ACC_BITS-1:0]   want;
  } dir_row_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] product;
    logic [POS_BITS-1:0]        row;
    logic [POS_BITS-1:0]        col;
    logic                       last;
  } element_t;

  typedef struct packed {
    logic [1:0]                op;
    logic [POS_BITS-1:0]       row;
    logic [POS_BITS-1:0]       col;
    logic signed [IN_BITS-1:0] value;
  } load_req_t;

  logic clk;
  logic rst;

  mm_in_if  item_ch ();
  mm_out_if result_ch ();
  mm_cfg_if cfg_ch ();

  matrix_multiply dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  logic signed [VALUE_BITS-1:0] left_cells [CELLS];
  logic signed [VALUE_BITS-1:0] right_cells [CELLS];
  bit                           left_loaded [CELLS];
  bit                           right_loaded [CELLS];
  logic [DIM_FIELD-1:0]         rows_cfg;
  logic [DIM_FIELD-1:0]         inner_cfg;
  logic [DIM_FIELD-1:0]         cols_cfg;
  element_t                     due_elements [$];
  int                           mismatch_count = 0;
  int                           items_sent;
  int                           cycle_count = 0;
  bit                           steady;

  localparam int DIR_ROWS = 23;
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_CFG,  OP_LOAD_LEFT,  3'd0, 3'd0, 16'sh0000, CFG_ROWS_A,     4'd1,  1'b0, 35'sd0},
    '{ROW_CFG,  OP_LOAD_LEFT,  3'd0, 3'd0, 16'sh0000, CFG_INNER_SIZE, 4'd1,  1'b0, 35'sd0},
    '{ROW_CFG,  OP_LOAD_LEFT,  3'd0, 3'd0, 16'sh0000, CFG_COLS_B,     4'd1,  1'b0, 35'sd0},
    '{ROW_ITEM, OP_LOAD_LEFT,  3'd0, 3'd0, 16'sh8000, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0},
    '{ROW_ITEM, OP_LOAD_RIGHT, 3'd0, 3'd0, 16'sh8000, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0},
    '{ROW_ITEM, OP_COMPUTE,    3'd7, 3'd7, 16'shffff, CFG_ROWS_A,     4'd0,  1'b1,
      35'sd1073741824},
    '{ROW_ITEM, OP_LOAD_LEFT,  3'd0, 3'd0, 16'sh7fff, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0},
    '{ROW_ITEM, OP_COMPUTE,    3'd0, 3'd0, 16'sh0000, CFG_ROWS_A,     4'd0,  1'b1,
      -35'sd1073709056},
    '{ROW_ITEM, OP_LOAD_RIGHT, 3'd0, 3'd0, 16'sh7fff, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0},
    '{ROW_ITEM, OP_COMPUTE,    3'd0, 3'd0, 16'sh0000, CFG_ROWS_A,     4'd0,  1'b1,
      35'sd1073676289},
    '{ROW_ITEM, OP_LOAD_LEFT,  3'd0, 3'd0, 16'sh0100, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0},
    '{ROW_ITEM, OP_LOAD_RIGHT, 3'd0, 3'd0, 16'shff00, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0},
    '{ROW_ITEM, OP_COMPUTE,    3'd0, 3'd0, 16'sh0000, CFG_ROWS_A,     4'd0,  1'b1, -35'sd65536},
    '{ROW_ITEM, OP_UNUSED,     3'd5, 3'd2, 16'sh1234, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0},
    '{ROW_ITEM, OP_LOAD_LEFT,  3'd7, 3'd7, 16'sh5a5a, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0},
    '{ROW_ITEM, OP_LOAD_RIGHT, 3'd7, 3'd7, 16'sha5a5, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0},
    '{ROW_CFG,  OP_LOAD_LEFT,  3'd0, 3'd0, 16'sh0000, CFG_INNER_SIZE, 4'd0,  1'b0, 35'sd0},
    '{ROW_ITEM, OP_COMPUTE,    3'd0, 3'd0, 16'sh0000, CFG_ROWS_A,     4'd0,  1'b1, 35'sd0},
    '{ROW_CFG,  OP_LOAD_LEFT,  3'd0, 3'd0, 16'sh0000, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0},
    '{ROW_ITEM, OP_COMPUTE,    3'd0, 3'd0, 16'sh0000, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0},
    '{ROW_CFG,  OP_LOAD_LEFT,  3'd0, 3'd0, 16'sh0000, CFG_ROWS_A,     4'd15, 1'b0, 35'sd0},
    '{ROW_CFG,  OP_LOAD_LEFT,  3'd0, 3'd0, 16'sh0000, CFG_COLS_B,     4'd15, 1'b0, 35'sd0},
    '{ROW_ITEM, OP_COMPUTE,    3'd0, 3'd0, 16'sh0000, CFG_ROWS_A,     4'd0,  1'b0, 35'sd0}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // compare each result transaction with the oldest predicted element
  always @(posedge clk) begin
    element_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (due_elements.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d at (%0d,%0d)", $time,
                 result_ch.product_value, result_ch.result_row, result_ch.result_col);
        mismatch_count++;
      end else begin
        want = due_elements.pop_front();
        if (result_ch.product_value !== want.product) begin
          $display("%0t: product_value expected %0d, got %0d", $time, want.product,
                   result_ch.product_value);
          mismatch_count++;
        end
        if (result_ch.result_row !== want.row) begin
          $display("%0t: result_row expected %0d, got %0d", $time, want.row,
                   result_ch.result_row);
          mismatch_count++;
        end
        if (result_ch.result_col !== want.col) begin
          $display("%0t: result_col expected %0d, got %0d", $time, want.col,
                   result_ch.result_col);
          mismatch_count++;
        end
        if (result_ch.last !== want.last) begin
          $display("%0t: last expected %0d, got %0d", $time, want.last, result_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int effective_dim(logic [DIM_FIELD-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  // queue one expected result transaction behind the others
  function automatic void append_due(element_t e);
    due_elements.insert(due_elements.size(), e);
  endfunction

  // store update for loads, full product for a compute
  function automatic void predict_item(logic [1:0] op, logic [POS_BITS-1:0] row,
                                       logic [POS_BITS-1:0] col,
                                       logic signed [IN_BITS-1:0] value);
    int       nr;
    int       nk;
    int       nc;
    longint   acc;
    element_t e;
    nr = effective_dim(rows_cfg);
    nk = effective_dim(inner_cfg);
    nc = effective_dim(cols_cfg);
    if (op == OP_LOAD_LEFT) begin
      left_cells[row * MAX_DIM + col] = value;
      left_loaded[row * MAX_DIM + col] = 1'b1;
    end else if (op == OP_LOAD_RIGHT) begin
      right_cells[row * MAX_DIM + col] = value;
      right_loaded[row * MAX_DIM + col] = 1'b1;
    end else if (op == OP_COMPUTE) begin
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          acc = 0;
          for (int k = 0; k < nk; k++) begin
            acc += longint'(left_cells[r * MAX_DIM + k]) * longint'(right_cells[k * MAX_DIM + c]);
          end
          e.product = acc[ACC_BITS-1:0];
          e.row = POS_BITS'(r);
          e.col = POS_BITS'(c);
          e.last = (r == nr - 1) && (c == nc - 1);
          append_due(e);
        end
      end
    end
  endfunction

  function automatic logic signed [IN_BITS-1:0] random_element();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return IN_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [1:0] op, logic [POS_BITS-1:0] row,
                           logic [POS_BITS-1:0] col, logic signed [IN_BITS-1:0] value,
                           bit predicted);
    while (!steady && $urandom_range(0, 99) < 33) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op <= op;
    item_ch.row_index <= row;
    item_ch.col_index <= col;
    item_ch.element_value <= value;
    do @(posedge clk); while (!item_ch.ready);
    if (op != OP_UNUSED) items_sent++;
    if (predicted) predict_item(op, row, col, value);
  endtask

  task automatic write_dim(cfg_index_t idx, logic [DIM_FIELD-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_ROWS_A:     rows_cfg = data;
      CFG_INNER_SIZE: inner_cfg = data;
      CFG_COLS_B:     cols_cfg = data;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain all pending results, then let the block go idle
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (due_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    bit                   after_items;
    int                   phase;
    int                   kind;
    int                   nr;
    int                   nk;
    int                   nc;
    logic [DIM_FIELD-1:0] dim_r;
    logic [DIM_FIELD-1:0] dim_k;
    logic [DIM_FIELD-1:0] dim_c;
    logic signed [IN_BITS-1:0] right_fill;
    load_req_t            loads [$];
    load_req_t            req;
    load_req_t            tmp;
    int                   j;

    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.op <= OP_LOAD_LEFT;
    item_ch.row_index <= '0;
    item_ch.col_index <= '0;
    item_ch.element_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_ROWS_A;
    cfg_ch.data <= '0;
    rows_cfg = 4'd8;
    inner_cfg = 4'd8;
    cols_cfg = 4'd8;
    items_sent = 0;
    steady = 1'b0;
    after_items = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (after_items) settle();
        after_items = 1'b0;
        write_dim(directed_rows[i].reg_index, directed_rows[i].reg_data);
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].row, directed_rows[i].col,
                  directed_rows[i].value, !directed_rows[i].checked);
        if (directed_rows[i].checked)
          append_due(element_t'{directed_rows[i].want, 3'd0, 3'd0, 1'b1});
        after_items = 1'b1;
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      steady = (phase >= 3 && phase < 7);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        dim_r = DIM_FIELD'($urandom_range(8, 15));
        dim_k = DIM_FIELD'($urandom_range(8, 15));
        dim_c = DIM_FIELD'($urandom_range(8, 15));
      end else if (kind == 1) begin
        dim_r = DIM_FIELD'($urandom_range(0, 3));
        dim_k = DIM_FIELD'($urandom_range(0, 8));
        dim_c = DIM_FIELD'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) dim_r = 4'd0;
        else dim_c = 4'd0;
      end else if (kind == 2) begin
        dim_r = 4'd1;
        dim_k = 4'd8;
        dim_c = 4'd1;
      end else begin
        dim_r = DIM_FIELD'($urandom_range(1, 4));
        dim_k = (kind == 3) ? 4'd0 : DIM_FIELD'($urandom_range(1, 4));
        dim_c = DIM_FIELD'($urandom_range(1, 4));
      end
      nr = effective_dim(dim_r);
      nk = effective_dim(dim_k);
      nc = effective_dim(dim_c);

      settle();
      write_dim(CFG_ROWS_A, dim_r);
      write_dim(CFG_INNER_SIZE, dim_k);
      write_dim(CFG_COLS_B, dim_c);

      // every entry the product reads gets written first
      loads.delete();
      right_fill = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      for (int r = 0; r < nr; r++) begin
        for (int k = 0; k < nk; k++) begin
          if (kind == 2 || !left_loaded[r * MAX_DIM + k])
            loads.insert(loads.size(), load_req_t'{OP_LOAD_LEFT, POS_BITS'(r), POS_BITS'(k),
                                        (kind == 2) ? 16'sh8000 : random_element()});
        end
      end
      for (int k = 0; k < nk; k++) begin
        for (int c = 0; c < nc; c++) begin
          if (kind == 2 || !right_loaded[k * MAX_DIM + c])
            loads.insert(loads.size(), load_req_t'{OP_LOAD_RIGHT, POS_BITS'(k), POS_BITS'(c),
                                        (kind == 2) ? right_fill : random_element()});
        end
      end
      if (kind != 2) begin
        repeat ($urandom_range(0, 4)) begin
          req.op = $urandom_range(0, 1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT;
          req.row = POS_BITS'($urandom_range(0, 7));
          req.col = POS_BITS'($urandom_range(0, 7));
          req.value = random_element();
          loads.insert(loads.size(), req);
        end
      end
      for (int i = loads.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = loads[i];
        loads[i] = loads[j];
        loads[j] = tmp;
      end

      foreach (loads[i]) begin
        if ($urandom_range(0, 9) == 0)
          send_item(OP_UNUSED, 3'($urandom), 3'($urandom), IN_BITS'($urandom), 1'b1);
        send_item(loads[i].op, loads[i].row, loads[i].col, loads[i].value, 1'b1);
      end
      send_item(OP_COMPUTE, 3'($urandom), 3'($urandom), IN_BITS'($urandom), 1'b1);

      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 4))
          send_item($urandom_range(0, 1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT, 3'($urandom),
                    3'($urandom), random_element(), 1'b1);
        send_item(OP_COMPUTE, 3'($urandom), 3'($urandom), IN_BITS'($urandom), 1'b1);
      end
    end
    steady = 1'b0;

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/mm_pkg.sv
rtl/mm_in_if.sv
rtl/mm_out_if.sv
rtl/mm_cfg_if.sv
rtl/mm_datapath.sv
rtl/mm_ctrl.sv
rtl/matrix_multiply.sv
verif/matrix_multiply_test.sv
